/* design/plte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_pkg: shared types and constants for the pointer list table engine
// Sizes of the entry store, field widths, command and status codes, and the
// control and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plte_pkg;

  localparam int DEPTH       = 256;
  localparam int ENTRY_WIDTH = 32;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int LEN_W = $clog2(DEPTH + 1);

  // fixed port widths
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 8;
  localparam int CNT_W    = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_DROP   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_FIND   = 3'd3,
    CMD_VACANT = 3'd4,
    CMD_COUNT  = 3'd5
  } cmd_t;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input transfer
    logic exec;   // check the command, set up the walk or finish at once
    logic walk;   // step through the entries
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;   // output register still holds a result
    logic quick;      // command finishes in the execute cycle
    logic walk_done;  // walk has its answer this cycle
  } sts_t;

endpackage

/* design/pointer_list_table_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_list_table_engine_top: list of entries with append, drop and search
// Top level: command sequencer plus entry store datapath.
// ----------------------------------------------------------------------------
// One command is worked on at a time; the next is taken once the current one
// has written its result to the output register, even while that result
// still waits to be taken. Append, unknown commands and out-of-range drop or
// read finish in the execute step; an in-range read walks a single entry.
// Find, vacant search and count walk the stored entries through the single
// RAM read port, one entry per cycle; a search stops early when it hits. A
// drop moves the entries above the index down one per cycle. A command
// waits in its execute cycle while a previous result is still held. The
// entry store needs no clearing after reset: only entries below the used
// length are ever read.
module pointer_list_table_engine_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [plte_pkg::CMD_W-1:0]      in_command,
  input  logic [plte_pkg::VAL_W-1:0]      in_item_value,
  input  logic [plte_pkg::POS_W-1:0]      in_position,
  input  logic                            in_backwards,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [plte_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_found,
  output logic [plte_pkg::RIDX_W-1:0]     out_result_index,
  output logic [plte_pkg::VAL_W-1:0]      out_read_value,
  output logic [plte_pkg::CNT_W-1:0]      out_match_count,
  output logic [plte_pkg::CNT_W-1:0]      out_list_length
);
  import plte_pkg::*;

  ctl_t ctl;
  sts_t sts;

  plte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  plte_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .in_backwards     (in_backwards),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_read_value   (out_read_value),
    .out_match_count  (out_match_count),
    .out_list_length  (out_list_length)
  );

`ifndef SYNTHESIS
  // one command at a time: busy right after a transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a command is in progress");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_list_length <= CNT_W'(DEPTH))
    else $error("list length above depth");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (!out_found && out_read_value == '0
      && out_match_count == '0))
    else $error("flagged command carries result data");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK && out_match_count == '0))
    else $error("search hit with bad status or count");

  // a result only changes the length through its own completion
  a_len_stable_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.walk && !sts.walk_done) |=> $stable(out_list_length))
    else $error("length changed in the middle of a walk");
`endif

endmodule

/* design/plte_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module plte_ram #(
  parameter int DATA_W    = 32,
  parameter int NUM_WORDS = 256
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(NUM_WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]            wdata,
  input  logic [$clog2(NUM_WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]            rdata
);

  logic [DATA_W-1:0] mem [NUM_WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/plte_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_ctrl: command sequencer
// Takes one command at a time, waits for a free output register, then either
// finishes at once or steps the datapath through the stored entries.
// ----------------------------------------------------------------------------
module plte_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  plte_pkg::sts_t  sts,
  output plte_pkg::ctl_t  ctl
);
  import plte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_WALK = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        ctl.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the previous result has been taken
        if (!sts.out_busy) begin
          ctl.exec  = 1'b1;
          state_nxt = sts.quick ? S_IDLE : S_WALK;
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

/* design/plte_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_dp: entry store, walk pointer and result register
// Holds the entries in a RAM, walks them one read per cycle for reads, searches,
// counts and drops, and builds the result in the output register.
// ----------------------------------------------------------------------------
module plte_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  plte_pkg::ctl_t                  ctl,
  output plte_pkg::sts_t                  sts,
  input  logic [plte_pkg::CMD_W-1:0]      in_command,
  input  logic [plte_pkg::VAL_W-1:0]      in_item_value,
  input  logic [plte_pkg::POS_W-1:0]      in_position,
  input  logic                            in_backwards,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [plte_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_found,
  output logic [plte_pkg::RIDX_W-1:0]     out_result_index,
  output logic [plte_pkg::VAL_W-1:0]      out_read_value,
  output logic [plte_pkg::CNT_W-1:0]      out_match_count,
  output logic [plte_pkg::CNT_W-1:0]      out_list_length
);
  import plte_pkg::*;

  // command held for the whole operation
  logic [CMD_W-1:0]       cmd_r;
  logic [ENTRY_WIDTH-1:0] val_r;
  logic [POS_W-1:0]       pos_r;
  logic                   back_r;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] addr_r, addr_nxt;
  logic             rd_ok_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             cand_r, cand_nxt;
  logic [IDX_W-1:0] cand_idx_r, cand_idx_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] st_r;
  logic                fnd_r;
  logic [RIDX_W-1:0]   ridx_r;
  logic [VAL_W-1:0]    rval_r;
  logic [CNT_W-1:0]    mcnt_r;

  logic [ENTRY_WIDTH-1:0] rdata;
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;

  logic pos_bad, full, is_zero, is_eq, vac_back, walk_dn;
  logic hit, ended, quick, issue, finish;

  logic [STATUS_W-1:0] res_st;
  logic                res_fnd;
  logic [IDX_W-1:0]    res_idx;
  logic [VAL_W-1:0]    res_rval;
  logic [CNT_W-1:0]    res_mcnt;
  logic [LEN_W-1:0]    res_len;

  plte_ram #(
    .DATA_W    (ENTRY_WIDTH),
    .NUM_WORDS (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (rdata)
  );

  assign pos_bad  = (32'(pos_r) >= 32'(len_r));
  assign full     = (len_r == LEN_W'(DEPTH));
  assign is_zero  = (rdata == '0);
  assign is_eq    = (rdata == val_r);
  assign vac_back = (cmd_r == CMD_VACANT) && back_r;
  assign walk_dn  = back_r && ((cmd_r == CMD_FIND) || (cmd_r == CMD_VACANT));
  assign ended    = (rem_r == '0) && !rd_ok_r;
  assign issue    = ctl.walk && (rem_r != '0);

  always_comb begin
    case (cmd_r)
      CMD_FIND:   hit = rd_ok_r && is_eq;
      // backward: a nonzero entry below a zero run closes the run
      CMD_VACANT: hit = back_r ? (rd_ok_r && !is_zero && cand_r) : (rd_ok_r && is_zero);
      CMD_READ:   hit = rd_ok_r;
      default:    hit = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_r)
      CMD_APPEND: quick = 1'b1;
      CMD_DROP:   quick = pos_bad;
      CMD_READ:   quick = pos_bad;
      CMD_FIND:   quick = 1'b0;
      CMD_VACANT: quick = 1'b0;
      CMD_COUNT:  quick = 1'b0;
      default:    quick = 1'b1;
    endcase
  end

  assign sts.out_busy  = out_valid_r;
  assign sts.quick     = quick;
  assign sts.walk_done = hit || ended;

  assign finish = (ctl.exec && quick) || (ctl.walk && (hit || ended));

  // result of the current command
  always_comb begin
    res_st   = ST_OK;
    res_fnd  = 1'b0;
    res_idx  = '0;
    res_rval = '0;
    res_mcnt = '0;
    res_len  = len_r;
    case (cmd_r)
      CMD_APPEND: begin
        if (full) begin
          res_st = ST_FULL;
        end else begin
          res_len = len_r + 1'b1;
        end
      end
      CMD_DROP: begin
        if (ctl.exec) begin
          res_st = ST_BAD_INDEX;
        end else begin
          res_len = len_r - 1'b1;
        end
      end
      CMD_READ: begin
        if (ctl.exec) begin
          res_st = ST_BAD_INDEX;
        end else begin
          res_rval = VAL_W'(rdata);
        end
      end
      CMD_FIND: begin
        res_fnd = hit;
        res_idx = hit ? rd_idx_r : '0;
      end
      CMD_VACANT: begin
        res_fnd = hit || (vac_back && cand_r);
        if (res_fnd) begin
          res_idx = vac_back ? cand_idx_r : rd_idx_r;
        end
      end
      CMD_COUNT: begin
        res_mcnt = CNT_W'(cnt_r);
      end
      default: ;
    endcase
  end

  // walk setup and stepping
  always_comb begin
    addr_nxt     = addr_r;
    rem_nxt      = rem_r;
    cand_nxt     = cand_r;
    cand_idx_nxt = cand_idx_r;
    cnt_nxt      = cnt_r;
    if (ctl.exec) begin
      cand_nxt     = 1'b0;
      cand_idx_nxt = '0;
      cnt_nxt      = '0;
      case (cmd_r)
        CMD_DROP: begin
          addr_nxt = IDX_W'(32'(pos_r) + 1);
          rem_nxt  = len_r - 1'b1 - LEN_W'(pos_r);
        end
        CMD_READ: begin
          addr_nxt = IDX_W'(pos_r);
          rem_nxt  = LEN_W'(1);
        end
        default: begin
          addr_nxt = walk_dn ? IDX_W'(len_r - 1'b1) : '0;
          rem_nxt  = len_r;
        end
      endcase
    end else if (ctl.walk) begin
      if (issue) begin
        addr_nxt = walk_dn ? addr_r - 1'b1 : addr_r + 1'b1;
        rem_nxt  = rem_r - 1'b1;
      end
      if (rd_ok_r && vac_back && is_zero) begin
        cand_nxt     = 1'b1;
        cand_idx_nxt = rd_idx_r;
      end
      if (rd_ok_r && (cmd_r == CMD_COUNT) && is_eq) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // append writes at the end; drop moves each read entry down by one
  always_comb begin
    if (cmd_r == CMD_APPEND) begin
      ram_we    = ctl.exec && !full;
      ram_waddr = len_r[IDX_W-1:0];
      ram_wdata = val_r;
    end else begin
      ram_we    = ctl.walk && rd_ok_r && (cmd_r == CMD_DROP);
      ram_waddr = rd_idx_r - 1'b1;
      ram_wdata = rdata;
    end
  end

  assign len_nxt = finish ? res_len : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      rd_ok_r     <= issue;
      out_valid_r <= finish || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      val_r  <= ENTRY_WIDTH'(in_item_value);
      pos_r  <= in_position;
      back_r <= in_backwards;
    end
    addr_r     <= addr_nxt;
    rem_r      <= rem_nxt;
    rd_idx_r   <= addr_r;
    cand_r     <= cand_nxt;
    cand_idx_r <= cand_idx_nxt;
    cnt_r      <= cnt_nxt;
    if (finish) begin
      st_r   <= res_st;
      fnd_r  <= res_fnd;
      ridx_r <= RIDX_W'(res_idx);
      rval_r <= res_rval;
      mcnt_r <= res_mcnt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = st_r;
  assign out_found        = fnd_r;
  assign out_result_index = ridx_r;
  assign out_read_value   = rval_r;
  assign out_match_count  = mcnt_r;
  assign out_list_length  = CNT_W'(len_r);

endmodule

/* test/plte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plte_checker: scoreboard for the pointer list table engine
// Watches both channels. Keeps its own copy of the entry store and the used
// length, works out the result of every accepted command and compares each
// accepted result field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module plte_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [plte_pkg::CMD_W-1:0]    in_command,
  input  logic [plte_pkg::VAL_W-1:0]    in_item_value,
  input  logic [plte_pkg::POS_W-1:0]    in_position,
  input  logic                          in_backwards,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [plte_pkg::STATUS_W-1:0] out_status,
  input  logic                          out_found,
  input  logic [plte_pkg::RIDX_W-1:0]   out_result_index,
  input  logic [plte_pkg::VAL_W-1:0]    out_read_value,
  input  logic [plte_pkg::CNT_W-1:0]    out_match_count,
  input  logic [plte_pkg::CNT_W-1:0]    out_list_length,
  output int                            fail_count,
  output int                            pending,
  output int                            list_fill
);
  import plte_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [RIDX_W-1:0]   index;
    logic [VAL_W-1:0]    value;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    length;
  } list_result_t;

  logic [ENTRY_WIDTH-1:0] store [DEPTH];
  int                     fill;
  int                     fails = 0;
  list_result_t           awaited [$];

  // Apply one command to the shadow store and return the result it yields.
  task automatic run_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                             input logic [POS_W-1:0] pos, input logic back,
                             output list_result_t res);
    logic [ENTRY_WIDTH-1:0] key;
    int                     i;
    int                     k;
    int                     hits;
    bit                     hit;
    res  = '0;
    key  = val[ENTRY_WIDTH-1:0];
    hits = 0;
    hit  = 1'b0;
    case (cmd)
      CMD_APPEND: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          store[fill] = key;
          fill++;
        end
      end
      CMD_DROP: begin
        if (pos >= fill) begin
          res.status = ST_BAD_INDEX;
        end else begin
          for (k = pos + 1; k < fill; k++) store[k-1] = store[k];
          fill--;
        end
      end
      CMD_READ: begin
        if (pos >= fill) res.status = ST_BAD_INDEX;
        else res.value = store[pos];
      end
      CMD_FIND: begin
        for (i = 0; i < fill && !hit; i++) begin
          k = back ? fill - 1 - i : i;
          if (store[k] == key) begin
            hit       = 1'b1;
            res.found = 1'b1;
            res.index = k[RIDX_W-1:0];
          end
        end
      end
      CMD_VACANT: begin
        // going down, a zero only counts where the run of zeros starts
        for (i = 0; i < fill && !hit; i++) begin
          k = back ? fill - 1 - i : i;
          if (store[k] == '0 && (!back || k == 0 || store[k-1] != '0)) begin
            hit       = 1'b1;
            res.found = 1'b1;
            res.index = k[RIDX_W-1:0];
          end
        end
      end
      CMD_COUNT: begin
        for (i = 0; i < fill; i++) if (store[i] == key) hits++;
        res.count = hits[CNT_W-1:0];
      end
      default: ;
    endcase
    res.length = fill[CNT_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : monitor
    list_result_t want;
    list_result_t cmd_res;
    if (!rst_n) begin
      fill = 0;
      awaited.delete();
      fail_count <= fails;
      pending    <= 0;
      list_fill  <= 0;
    end else begin
      // retire the result before taking a new command in the same cycle
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          $error("result transfer with no command outstanding");
          fails++;
        end else begin
          want = awaited.pop_front();
          check_field("status", want.status, out_status);
          check_field("found", want.found, out_found);
          check_field("result_index", want.index, out_result_index);
          check_field("read_value", want.value, out_read_value);
          check_field("match_count", want.count, out_match_count);
          check_field("list_length", want.length, out_list_length);
        end
      end
      if (in_valid && !in_stall) begin
        run_command(in_command, in_item_value, in_position, in_backwards, cmd_res);
        awaited.push_back(cmd_res);
      end
      fail_count <= fails;
      pending    <= awaited.size();
      list_fill  <= fill;
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the pointer list table engine
// Directed commands on an empty and a short list, then random command phases
// that grow the list to full, mix all commands and shrink it again, with
// random idling on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import plte_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 3000;
  localparam int QUIET_FROM   = 800;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int LIMIT        = 1_200_000;

  typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [VAL_W-1:0]    in_item_value;
  logic [POS_W-1:0]    in_position;
  logic                in_backwards;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [RIDX_W-1:0]   out_result_index;
  logic [VAL_W-1:0]    out_read_value;
  logic [CNT_W-1:0]    out_match_count;
  logic [CNT_W-1:0]    out_list_length;
  int                  fail_count;
  int                  pending;
  int                  list_fill;

  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  bit quiet     = 1'b0;

  pointer_list_table_engine_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .in_backwards     (in_backwards),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_read_value   (out_read_value),
    .out_match_count  (out_match_count),
    .out_list_length  (out_list_length)
  );

  plte_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_item_value    (in_item_value),
    .in_position      (in_position),
    .in_backwards     (in_backwards),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_result_index (out_result_index),
    .out_read_value   (out_read_value),
    .out_match_count  (out_match_count),
    .out_list_length  (out_list_length),
    .fail_count       (fail_count),
    .pending          (pending),
    .list_fill        (list_fill)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one command from a falling edge and hold it until the transfer.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos, input logic back);
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_item_value <= val;
    in_position   <= pos;
    in_backwards  <= back;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // result side: random stall bursts, one long hold-off on request
  initial begin : receiver
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_done = 1'b1;
      end else if (rst_n && !quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 15);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin : stimulus
    int                 n;
    int                 r;
    phase_t             phase;
    logic [CMD_W-1:0]   cmd;
    logic [VAL_W-1:0]   val;
    logic [POS_W-1:0]   pos;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_APPEND;
    in_item_value = '0;
    in_position   = '0;
    in_backwards  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list: bad index, searches with nothing to walk, unknown codes
    send_item(CMD_READ, '0, '0, 1'b0);
    send_item(CMD_DROP, '0, '0, 1'b0);
    send_item(CMD_FIND, '0, '0, 1'b1);
    send_item(CMD_VACANT, '0, '0, 1'b1);
    send_item(CMD_COUNT, '0, '0, 1'b0);
    send_item(CMD_UNUSED_LO, '1, '1, 1'b1);
    // build 0, max, 0, 0, 5, 0, 0: three zero runs, the upper two each two long
    send_item(CMD_APPEND, '0, '0, 1'b0);
    send_item(CMD_APPEND, '1, '1, 1'b1);
    send_item(CMD_APPEND, '0, '0, 1'b0);
    send_item(CMD_APPEND, '0, '0, 1'b0);
    send_item(CMD_APPEND, 32'd5, '0, 1'b0);
    send_item(CMD_APPEND, '0, '0, 1'b0);
    send_item(CMD_APPEND, '0, '0, 1'b0);
    send_item(CMD_FIND, '0, '0, 1'b0);
    send_item(CMD_FIND, '0, '0, 1'b1);
    send_item(CMD_FIND, '1, '0, 1'b0);
    send_item(CMD_VACANT, '1, '0, 1'b0);
    send_item(CMD_VACANT, '0, '0, 1'b1);
    send_item(CMD_COUNT, '0, '0, 1'b1);
    send_item(CMD_READ, '0, 8'd1, 1'b0);
    send_item(CMD_READ, '0, '1, 1'b0);
    send_item(CMD_DROP, '0, '1, 1'b0);
    send_item(CMD_DROP, '0, 8'd0, 1'b0);
    send_item(CMD_DROP, '0, 8'd5, 1'b0);
    send_item(CMD_FIND, 32'h1234_5678, '0, 1'b1);
    send_item(CMD_UNUSED_HI, '0, '0, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n >= QUIET_FROM) quiet = 1'b1;
      if (n < 330) phase = PH_GROW;
      else if (n < 480) phase = PH_MIXED;
      else if (n < 760) phase = PH_SHRINK;
      else phase = PH_MIXED;

      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end

      // weighted command mix per phase: grow fills to full, shrink drains
      r = $urandom_range(0, 99);
      case (phase)
        PH_GROW: begin
          if (r < 80) cmd = CMD_APPEND;
          else if (r < 82) cmd = CMD_DROP;
          else if (r < 86) cmd = CMD_READ;
          else if (r < 90) cmd = CMD_FIND;
          else if (r < 94) cmd = CMD_VACANT;
          else if (r < 98) cmd = CMD_COUNT;
          else cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        end
        PH_SHRINK: begin
          if (r < 15) cmd = CMD_APPEND;
          else if (r < 70) cmd = CMD_DROP;
          else if (r < 75) cmd = CMD_READ;
          else if (r < 82) cmd = CMD_FIND;
          else if (r < 88) cmd = CMD_VACANT;
          else if (r < 96) cmd = CMD_COUNT;
          else cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        end
        default: begin
          if (r < 30) cmd = CMD_APPEND;
          else if (r < 50) cmd = CMD_DROP;
          else if (r < 62) cmd = CMD_READ;
          else if (r < 75) cmd = CMD_FIND;
          else if (r < 85) cmd = CMD_VACANT;
          else if (r < 96) cmd = CMD_COUNT;
          else cmd = r[0] ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        end
      endcase

      // favor zeros and a few repeated values so searches and counts hit
      r = $urandom_range(0, 9);
      if (r < 3) begin
        val = '0;
      end else if (r < 7) begin
        case ($urandom_range(0, 3))
          0:       val = 32'd1;
          1:       val = 32'd2;
          2:       val = '1;
          default: val = 32'h8000_0000;
        endcase
      end else begin
        val = $urandom;
      end

      if (list_fill > 0 && $urandom_range(0, 99) < 85)
        pos = 8'($urandom_range(0, list_fill - 1));
      else
        pos = 8'($urandom_range(0, 255));

      send_item(cmd, val, pos, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
